[hdl/bole_pkg.sv]
// ----------------------------------------------------------------------------
// bole_pkg: shared types and codes of the bounded ordered list engine
// Operation codes, status codes and the command/status structs that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int OP_WIDTH = 3;

  typedef enum logic [2:0] {
    OP_INSERT_FRONT = 3'd0,
    OP_INSERT_BACK  = 3'd1,
    OP_REMOVE_FRONT = 3'd2,
    OP_REMOVE_BACK  = 3'd3,
    OP_REMOVE_VALUE = 3'd4,
    OP_SEARCH       = 3'd5,
    OP_CLEAR        = 3'd6,
    OP_NONE         = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;        // capture the request
    logic    rd_head;     // read value/link memories at head
    logic    rd_tail;     // read value memory at tail
    logic    rd_next;     // read at link of the current node
    logic    step;        // advance walk: prev <= cur, cur <= link
    logic    ins_write;   // write new node and update pointers
    logic    pop_front;   // unlink head
    logic    pop_back;    // unlink tail, tail <= prev
    logic    unlink;      // unlink matched node
    logic    clear;       // empty the list
    logic    take_removed;// capture removed value
    logic    set_found;   // record a match at walk index
    logic    pop_free;    // read the free stack top
    logic    finish;      // write out result
    status_t status;
  } cmd_t;

  // Status back to the controller.
  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic one;
    logic match;      // value read matches request
    logic walk_last;  // the current node is the last one in the list
    logic back_done;  // walk reached the tail predecessor
  } stat_t;

endpackage

[hdl/bole_ram.sv]
// ----------------------------------------------------------------------------
// bole_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write-first is not needed; reads and writes never share a cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/bole_datapath.sv]
// ----------------------------------------------------------------------------
// bole_datapath: node storage, free stack and list pointers
// Holds the value and link memories, the free stack with its clear epoch,
// the head/tail/count registers, the walk registers and the result.
// ----------------------------------------------------------------------------
module bole_datapath #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2:0]           in_op,
  input  logic [31:0]          in_value,
  input  bole_pkg::cmd_t       cmd,
  output bole_pkg::stat_t      stat,
  output logic [31:0]          res_removed,
  output logic                 res_found,
  output logic [6:0]           res_position,
  output logic [6:0]           res_total,
  output logic [1:0]           res_status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Request and list state.
  bole_pkg::op_t          op;
  logic [VALUE_WIDTH-1:0] value;
  logic [AW-1:0]          head;
  logic [AW-1:0]          tail;
  logic [CW-1:0]          count;
  logic [AW-1:0]          cur;
  logic [AW-1:0]          prev;
  logic [CW-1:0]          walk_idx;
  logic [CW-1:0]          found_idx;
  logic [AW-1:0]          new_node;

  // Memory ports.
  logic                   val_we;
  logic [AW-1:0]          val_addr;
  logic [VALUE_WIDTH-1:0] val_rdata;
  logic                   lnk_we;
  logic [AW-1:0]          lnk_addr;
  logic [AW-1:0]          lnk_wdata;
  logic [AW-1:0]          lnk_rdata;
  logic                   fs_we;
  logic [AW-1:0]          fs_addr;
  logic [AW-1:0]          fs_rdata;

  // Free stack: an entry counts as written only if it was written since the
  // last clear; otherwise it reads as its own index.
  logic [CAPACITY-1:0]    fs_valid;
  logic [AW-1:0]          fs_addr_q;
  logic [AW-1:0]          top_idx;
  logic [AW-1:0]          free_node;
  logic [CW-1:0]          count_dec;

  assign count_dec = count - CW'(1);
  // Top of stack for a take: CAPACITY-count-1; for a give after decrement
  // the same formula with count-1.
  assign top_idx   = cmd.finish ? AW'(CAPACITY - 32'(count_dec) - 1)
                                : AW'(CAPACITY - 32'(count) - 1);
  assign free_node = fs_valid[fs_addr_q] ? fs_rdata : fs_addr_q;

  // Memory addressing.
  always_comb begin
    val_we    = 1'b0;
    val_addr  = cur;
    lnk_we    = 1'b0;
    lnk_addr  = cur;
    lnk_wdata = new_node;
    fs_we     = 1'b0;
    fs_addr   = top_idx;
    if (cmd.rd_head) begin
      val_addr = head;
      lnk_addr = head;
    end else if (cmd.rd_tail) begin
      val_addr = tail;
    end else if (cmd.rd_next) begin
      val_addr = lnk_rdata;
      lnk_addr = lnk_rdata;
    end else if (cmd.ins_write) begin
      val_we   = 1'b1;
      val_addr = new_node;
      if (count != '0 && op == bole_pkg::OP_INSERT_FRONT) begin
        lnk_we    = 1'b1;
        lnk_addr  = new_node;
        lnk_wdata = head;
      end else if (count != '0) begin
        lnk_we    = 1'b1;
        lnk_addr  = tail;
        lnk_wdata = new_node;
      end
    end else if (cmd.unlink && found_idx != '0) begin
      lnk_we    = 1'b1;
      lnk_addr  = prev;
      lnk_wdata = lnk_rdata;
    end
    if (cmd.finish && (cmd.pop_front || cmd.pop_back || cmd.unlink)) begin
      fs_we = 1'b1;
    end
  end

  bole_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_values (
    .clk(clk), .we(val_we), .addr(val_addr), .wdata(value), .rdata(val_rdata)
  );
  bole_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_links (
    .clk(clk), .we(lnk_we), .addr(lnk_addr), .wdata(lnk_wdata), .rdata(lnk_rdata)
  );
  bole_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
    .clk(clk), .we(fs_we), .addr(fs_addr), .wdata(cur), .rdata(fs_rdata)
  );

  // Status to the controller.
  always_comb begin
    stat.op        = op;
    stat.empty     = (count == '0);
    stat.full      = (count == CW'(CAPACITY));
    stat.one       = (count == CW'(1));
    stat.match     = (val_rdata == value);
    stat.walk_last = (walk_idx + CW'(1) >= count);
    stat.back_done = (walk_idx + CW'(2) >= count);
  end

  // Free stack valid bits.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fs_valid <= '0;
    end else if (fs_we) begin
      fs_valid[fs_addr] <= 1'b1;
    end
  end

  // Pointers, walk and result.
  always_ff @(posedge clk) begin
    fs_addr_q <= fs_addr;
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.clear) begin
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end
      if (cmd.ins_write) begin
        count <= count + CW'(1);
        if (count == '0) begin
          head <= new_node;
          tail <= new_node;
        end else if (op == bole_pkg::OP_INSERT_FRONT) begin
          head <= new_node;
        end else begin
          tail <= new_node;
        end
      end
      if (cmd.pop_front) begin
        count <= count_dec;
        head  <= (count_dec == '0) ? '0 : lnk_rdata;
        if (count_dec == '0) tail <= '0;
      end
      if (cmd.pop_back) begin
        count <= count_dec;
        if (count_dec == '0) begin
          head <= '0;
          tail <= '0;
        end else begin
          tail <= prev;
        end
      end
      if (cmd.unlink) begin
        count <= count_dec;
        if (count_dec == '0) begin
          head <= '0;
          tail <= '0;
        end else if (found_idx == '0) begin
          head <= lnk_rdata;
        end else if (found_idx + CW'(1) == count) begin
          tail <= prev;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op           <= bole_pkg::op_t'(in_op);
      value        <= in_value[VALUE_WIDTH-1:0];
      walk_idx     <= '0;
      found_idx    <= '0;
      res_removed  <= '0;
      res_found    <= 1'b0;
      res_position <= '0;
    end
    if (cmd.pop_free) begin
      new_node <= free_node;
    end
    if (cmd.rd_head) begin
      cur  <= head;
      prev <= head;
    end
    // The walk stops on the tail predecessor; keep it as the new tail.
    if (cmd.rd_tail) begin
      prev <= cur;
      cur  <= tail;
    end
    if (cmd.step) begin
      prev     <= cur;
      cur      <= lnk_rdata;
      walk_idx <= walk_idx + CW'(1);
    end
    if (cmd.take_removed) begin
      res_removed <= 32'(val_rdata);
    end
    if (cmd.set_found) begin
      res_found    <= 1'b1;
      res_position <= 7'(walk_idx);
      found_idx    <= walk_idx;
    end
    if (cmd.finish) begin
      res_status <= cmd.status;
    end
  end

  // Count after this request, valid once the result is out.
  assign res_total = 7'(count);

endmodule

[hdl/bole_ctrl.sv]
// ----------------------------------------------------------------------------
// bole_ctrl: request sequencer
// Accepts one request, steps the datapath through it and hands out one
// result transaction.
// ----------------------------------------------------------------------------
module bole_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  bole_pkg::stat_t stat,
  output bole_pkg::cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_FREE  = 9'b000000100,
    S_INS   = 9'b000001000,
    S_FRONT = 9'b000010000,
    S_BACK  = 9'b000100000,
    S_WALK  = 9'b001000000,
    S_UNL   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd        = '0;
    cmd.status = bole_pkg::ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      // Check preconditions and issue the first read.
      S_DEC: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
        unique case (stat.op)
          bole_pkg::OP_INSERT_FRONT, bole_pkg::OP_INSERT_BACK: begin
            if (stat.full) begin
              cmd.status = bole_pkg::ST_FULL;
            end else begin
              cmd.finish   = 1'b0;
              state_next   = S_FREE;
            end
          end
          bole_pkg::OP_REMOVE_FRONT: begin
            if (stat.empty) begin
              cmd.status = bole_pkg::ST_EMPTY;
            end else begin
              cmd.finish  = 1'b0;
              cmd.rd_head = 1'b1;
              state_next  = S_FRONT;
            end
          end
          bole_pkg::OP_REMOVE_BACK: begin
            if (stat.empty) begin
              cmd.status = bole_pkg::ST_EMPTY;
            end else begin
              cmd.finish  = 1'b0;
              cmd.rd_head = 1'b1;
              state_next  = S_BACK;
            end
          end
          bole_pkg::OP_REMOVE_VALUE, bole_pkg::OP_SEARCH: begin
            if (stat.empty) begin
              cmd.status = (stat.op == bole_pkg::OP_SEARCH) ?
                           bole_pkg::ST_NOT_FOUND : bole_pkg::ST_EMPTY;
            end else begin
              cmd.finish  = 1'b0;
              cmd.rd_head = 1'b1;
              state_next  = S_WALK;
            end
          end
          bole_pkg::OP_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      // Free stack read address settled in S_DEC; the read lands here.
      S_FREE: begin
        cmd.pop_free = 1'b1;
        state_next   = S_INS;
      end
      S_INS: begin
        cmd.ins_write = 1'b1;
        cmd.finish    = 1'b1;
        state_next    = S_OUT;
      end
      S_FRONT: begin
        cmd.take_removed = 1'b1;
        cmd.pop_front    = 1'b1;
        cmd.finish       = 1'b1;
        state_next       = S_OUT;
      end
      // Walk to the tail predecessor; tail value read at the end.
      S_BACK: begin
        if (stat.back_done) begin
          cmd.rd_tail = 1'b1;
          state_next  = S_UNL;
        end else begin
          cmd.step    = 1'b1;
          cmd.rd_next = 1'b1;
        end
      end
      S_WALK: begin
        if (stat.match) begin
          cmd.set_found = 1'b1;
          if (stat.op == bole_pkg::OP_SEARCH) begin
            cmd.finish = 1'b1;
            state_next = S_OUT;
          end else begin
            state_next = S_UNL;
          end
        end else if (stat.walk_last) begin
          cmd.finish = 1'b1;
          cmd.status = bole_pkg::ST_NOT_FOUND;
          state_next = S_OUT;
        end else begin
          cmd.step    = 1'b1;
          cmd.rd_next = 1'b1;
        end
      end
      S_UNL: begin
        cmd.finish = 1'b1;
        if (stat.op == bole_pkg::OP_REMOVE_BACK) begin
          cmd.take_removed = 1'b1;
          cmd.pop_back     = 1'b1;
        end else begin
          cmd.unlink = 1'b1;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/bounded_ordered_list_engine_top.sv]
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top: linked list request engine
// Top level joining the sequencer and the node storage datapath.
// ----------------------------------------------------------------------------
// One request at a time. Search, remove value and remove back walk the
// links one node per cycle through the single-port link memory. A result
// is held until taken; the next request is accepted the cycle after.
module bounded_ordered_list_engine_top #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // operation[2:0], value[34:3], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // removed_value[31:0], found[32],
                                 // position[39:33], entry_total[46:40],
                                 // status[48:47], zero fill
);

  bole_pkg::cmd_t  cmd;
  bole_pkg::stat_t stat;
  logic [31:0] res_removed;
  logic        res_found;
  logic [6:0]  res_position;
  logic [6:0]  res_total;
  logic [1:0]  res_status;

  bole_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .stat(stat), .cmd(cmd)
  );

  bole_datapath #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .in_op(s_tdata[2:0]), .in_value(s_tdata[34:3]),
    .cmd(cmd), .stat(stat), .res_removed(res_removed), .res_found(res_found),
    .res_position(res_position), .res_total(res_total), .res_status(res_status)
  );

  assign m_tdata = {7'b0, res_status, res_total, res_position, res_found,
                    res_removed};

endmodule

[hdl/bole_checker.sv]
// ----------------------------------------------------------------------------
// bole_checker: port-level checks of the list engine
// Watches the stream ports of the top level.
// ----------------------------------------------------------------------------
module bole_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // No request is taken while a result waits.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("request accepted with result pending");

  // An accepted request does not give a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !m_tvalid)
    else $error("result too early");

  // Found is never set together with a status other than ok.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[48:47] == 2'd0)
    else $error("found with error status");

endmodule

bind bounded_ordered_list_engine_top bole_checker u_bole_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bounded ordered list engine
// A directed table covers empty and full lists, every operation, value
// extremes and the head/tail removal corners. Random requests follow,
// mostly inserts and matching searches/removes on live values. Every
// result is compared field by field against a queue-based list predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 64;

  typedef struct packed {
    logic [31:0]       removed_value;
    logic              found;
    logic [6:0]        position;
    logic [6:0]        entry_total;
    bole_pkg::status_t status;
  } list_result_t;

  // One row of the directed table; chk marks a row with a typed-in result.
  typedef struct {
    bole_pkg::op_t op;
    logic [31:0]   value;
    bit            chk;
    list_result_t  res;
  } request_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  bounded_ordered_list_engine_top #(.CAPACITY(CAP), .VALUE_WIDTH(32)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: list contents, head first.
  logic [31:0]  model_list[$];
  list_result_t pending_results[$];
  int           error_count = 0;
  int           sent_count = 0;
  int           result_count = 0;
  int           idle_cycles = 0;
  bit           send_done = 1'b0;
  bit           full_seen = 1'b0;

  function automatic list_result_t list_apply(bole_pkg::op_t op, logic [31:0] v);
    list_result_t r;
    int idx;
    r = '0;
    r.status = bole_pkg::ST_OK;
    idx = -1;
    case (op)
      bole_pkg::OP_INSERT_FRONT, bole_pkg::OP_INSERT_BACK: begin
        if (model_list.size() >= CAP) r.status = bole_pkg::ST_FULL;
        else if (op == bole_pkg::OP_INSERT_FRONT) model_list.push_front(v);
        else model_list.push_back(v);
      end
      bole_pkg::OP_REMOVE_FRONT: begin
        if (model_list.size() == 0) r.status = bole_pkg::ST_EMPTY;
        else r.removed_value = model_list.pop_front();
      end
      bole_pkg::OP_REMOVE_BACK: begin
        if (model_list.size() == 0) r.status = bole_pkg::ST_EMPTY;
        else r.removed_value = model_list.pop_back();
      end
      bole_pkg::OP_REMOVE_VALUE, bole_pkg::OP_SEARCH: begin
        if (model_list.size() == 0) begin
          r.status = (op == bole_pkg::OP_REMOVE_VALUE) ? bole_pkg::ST_EMPTY
                                                       : bole_pkg::ST_NOT_FOUND;
        end else begin
          foreach (model_list[i]) if (idx < 0 && model_list[i] == v) idx = i;
          if (idx < 0) r.status = bole_pkg::ST_NOT_FOUND;
          else begin
            r.found = 1'b1;
            r.position = 7'(idx);
            if (op == bole_pkg::OP_REMOVE_VALUE) model_list.delete(idx);
          end
        end
      end
      bole_pkg::OP_CLEAR: model_list.delete();
      default: ;
    endcase
    r.entry_total = 7'(model_list.size());
    if (model_list.size() == CAP) full_seen = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch result %0d %s: got %h expected %h", result_count, what, got, want);
  endtask

  // Send one request; the expected result is queued at acceptance.
  task automatic send_request(bole_pkg::op_t op, logic [31:0] v, bit chk,
                              list_result_t typed);
    list_result_t r;
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, v, op};
    do @(posedge clk); while (!s_tready);
    r = list_apply(op, v);
    if (chk && r != typed) report_mismatch("table row", 32'(r), 32'(typed));
    pending_results.push_back(r);
    sent_count++;
  endtask

  function automatic list_result_t mk(logic [31:0] rv, bit f, int p, int n,
                                      bole_pkg::status_t s);
    list_result_t r;
    r.removed_value = rv; r.found = f; r.position = 7'(p);
    r.entry_total = 7'(n); r.status = s;
    return r;
  endfunction

  // Result side: random stall per transaction, check against the oldest.
  initial begin
    list_result_t got, want;
    int gap;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.removed_value = m_tdata[31:0];
      got.found         = m_tdata[32];
      got.position      = m_tdata[39:33];
      got.entry_total   = m_tdata[46:40];
      got.status        = bole_pkg::status_t'(m_tdata[48:47]);
      if (pending_results.size() == 0) begin
        error_count++;
        $display("unexpected result %h", m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.removed_value != want.removed_value)
          report_mismatch("removed_value", got.removed_value, want.removed_value);
        if (got.found != want.found) report_mismatch("found", got.found, want.found);
        if (got.position != want.position)
          report_mismatch("position", got.position, want.position);
        if (got.entry_total != want.entry_total)
          report_mismatch("entry_total", got.entry_total, want.entry_total);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
      end
      result_count++;
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    request_row_t table_rows[$];
    logic [31:0] v;
    int k, pick;
    bole_pkg::op_t op;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list errors, extremes, head/tail removal, full list.
    table_rows = '{
      '{bole_pkg::OP_REMOVE_FRONT, 32'h0, 1, mk(0, 0, 0, 0, bole_pkg::ST_EMPTY)},
      '{bole_pkg::OP_REMOVE_BACK,  32'h0, 1, mk(0, 0, 0, 0, bole_pkg::ST_EMPTY)},
      '{bole_pkg::OP_REMOVE_VALUE, 32'h5, 1, mk(0, 0, 0, 0, bole_pkg::ST_EMPTY)},
      '{bole_pkg::OP_SEARCH,       32'h5, 1, mk(0, 0, 0, 0, bole_pkg::ST_NOT_FOUND)},
      '{bole_pkg::OP_NONE,         32'hFFFF_FFFF, 1, mk(0, 0, 0, 0, bole_pkg::ST_OK)},
      '{bole_pkg::OP_INSERT_FRONT, 32'h8000_0000, 1, mk(0, 0, 0, 1, bole_pkg::ST_OK)},
      '{bole_pkg::OP_INSERT_BACK,  32'h7FFF_FFFF, 1, mk(0, 0, 0, 2, bole_pkg::ST_OK)},
      '{bole_pkg::OP_INSERT_FRONT, 32'hFFFF_FFFF, 1, mk(0, 0, 0, 3, bole_pkg::ST_OK)},
      '{bole_pkg::OP_INSERT_BACK,  32'h0, 1, mk(0, 0, 0, 4, bole_pkg::ST_OK)},
      '{bole_pkg::OP_SEARCH,       32'h0, 1, mk(0, 1, 3, 4, bole_pkg::ST_OK)},
      '{bole_pkg::OP_SEARCH,       32'h1234, 1, mk(0, 0, 0, 4, bole_pkg::ST_NOT_FOUND)},
      '{bole_pkg::OP_REMOVE_VALUE, 32'hFFFF_FFFF, 1, mk(0, 1, 0, 3, bole_pkg::ST_OK)},
      '{bole_pkg::OP_REMOVE_VALUE, 32'h0, 1, mk(0, 1, 2, 2, bole_pkg::ST_OK)},
      '{bole_pkg::OP_INSERT_BACK,  32'h55, 0, '0},
      '{bole_pkg::OP_REMOVE_BACK,  32'h0, 1, mk(32'h55, 0, 0, 2, bole_pkg::ST_OK)},
      '{bole_pkg::OP_REMOVE_FRONT, 32'h0, 1,
        mk(32'h8000_0000, 0, 0, 1, bole_pkg::ST_OK)},
      '{bole_pkg::OP_REMOVE_VALUE, 32'h7FFF_FFFF, 1, mk(0, 1, 0, 0, bole_pkg::ST_OK)},
      '{bole_pkg::OP_INSERT_BACK,  32'h9, 0, '0},
      '{bole_pkg::OP_REMOVE_BACK,  32'h0, 1, mk(32'h9, 0, 0, 0, bole_pkg::ST_OK)},
      '{bole_pkg::OP_INSERT_FRONT, 32'h3, 0, '0},
      '{bole_pkg::OP_CLEAR,        32'h0, 1, mk(0, 0, 0, 0, bole_pkg::ST_OK)}
    };
    foreach (table_rows[i])
      send_request(table_rows[i].op, table_rows[i].value, table_rows[i].chk,
                   table_rows[i].res);
    // Fill to capacity, then one over.
    for (k = 0; k < CAP; k++) send_request(bole_pkg::OP_INSERT_BACK, 32'(k * 3), 0, '0);
    send_request(bole_pkg::OP_INSERT_FRONT, 32'h1, 1,
                 mk(0, 0, 0, CAP, bole_pkg::ST_FULL));
    send_request(bole_pkg::OP_SEARCH, 32'(189), 1,
                 mk(0, 1, CAP - 1, CAP, bole_pkg::ST_OK));
    send_request(bole_pkg::OP_REMOVE_BACK, 32'h0, 1,
                 mk(32'(189), 0, 0, CAP - 1, bole_pkg::ST_OK));
    // Sender holds off until the engine has drained.
    s_tvalid <= 1'b0;
    wait (pending_results.size() == 0);

    // Random part: mostly inserts and hits on live values.
    for (k = 0; k < 1200; k++) begin
      pick = $urandom_range(0, 99);
      v = $urandom();
      if (pick < 40) op = (pick < 20) ? bole_pkg::OP_INSERT_FRONT : bole_pkg::OP_INSERT_BACK;
      else if (pick < 52) op = bole_pkg::OP_REMOVE_FRONT;
      else if (pick < 62) op = bole_pkg::OP_REMOVE_BACK;
      else if (pick < 78) op = bole_pkg::OP_REMOVE_VALUE;
      else if (pick < 97) op = bole_pkg::OP_SEARCH;
      else if (pick < 98) op = bole_pkg::OP_CLEAR;
      else op = bole_pkg::OP_NONE;
      if ((op == bole_pkg::OP_SEARCH || op == bole_pkg::OP_REMOVE_VALUE) &&
          model_list.size() > 0 && $urandom_range(0, 3) != 0)
        v = model_list[$urandom_range(0, model_list.size() - 1)];
      else if (pick < 40 && $urandom_range(0, 3) == 0)
        v = 32'($urandom_range(0, 7));  // duplicates exercise first-match
      send_request(op, v, 0, '0);
      if (k == 600) begin
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
      end
    end
    s_tvalid <= 1'b0;
    send_done = 1'b1;
    wait (pending_results.size() == 0);
    repeat (CAP + 10) @(posedge clk);

    $display("Covered %0d requests and %0d results, empty/full/not-found corners,",
             sent_count, result_count);
    $display("value extremes and random list traffic (capacity reached: %0d).", full_seen);
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[bounded_ordered_list_engine_top.f]
hdl/bole_pkg.sv
hdl/bole_ram.sv
hdl/bole_datapath.sv
hdl/bole_ctrl.sv
hdl/bounded_ordered_list_engine_top.sv
hdl/bole_checker.sv
dv/tb.sv
